// ===== rtl/core/tpe_pkg.sv =====
// package for the two-level product term evaluator: types, codes and sizes
package tpe_pkg;

    localparam int STATUS_BITS    = 128;
    localparam int HALF_BITS      = 64;
    localparam int COUNT_W        = 7;
    localparam int CMD_W          = 3;
    localparam int BIT_IDX_W      = 7;
    localparam int ENTRY_W        = 6;
    localparam int CFG_IDX_W      = 1;
    localparam int PREP_TERMS_DEF = 64;
    localparam int MAIN_TERMS_DEF = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET_BIT   = 3'd0,
        CMD_CLEAR_BIT = 3'd1,
        CMD_APPLY     = 3'd2,
        CMD_LOAD_PREP = 3'd3,
        CMD_LOAD_MAIN = 3'd4,
        CMD_EVALUATE  = 3'd5
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PREP_COUNT = 1'b0,
        CFG_MAIN_COUNT = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_PREP = 2'd1,
        ST_MAIN = 2'd2
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]     command;
        logic [BIT_IDX_W-1:0] bit_index;
        logic [ENTRY_W-1:0]   entry_index;
        logic [HALF_BITS-1:0] word_a_lo;
        logic [HALF_BITS-1:0] word_a_hi;
        logic [HALF_BITS-1:0] word_b_lo;
        logic [HALF_BITS-1:0] word_b_hi;
    } in_beat_t;

    typedef struct packed {
        logic [HALF_BITS-1:0] eval_lo;
        logic [HALF_BITS-1:0] eval_hi;
        logic                 recalc_pending;
    } out_beat_t;

    typedef struct packed {
        logic                   valid;
        logic [STATUS_BITS-1:0] word;
        logic [STATUS_BITS-1:0] acc;
    } token_t;

    typedef struct packed {
        logic                   we;
        logic [ENTRY_W-1:0]     index;
        logic [STATUS_BITS-1:0] mask;
        logic [STATUS_BITS-1:0] result;
    } load_t;

endpackage

// ===== rtl/core/tpe_cell.sv =====
// one cell: holds one product term and tests the passing token against it
module tpe_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tpe_pkg::load_t                load,
    input  logic [tpe_pkg::COUNT_W-1:0]   count,
    input  tpe_pkg::token_t               tok_in,
    output tpe_pkg::token_t               tok_out
);

    logic [tpe_pkg::STATUS_BITS-1:0] mask_reg;
    logic [tpe_pkg::STATUS_BITS-1:0] result_reg;
    logic                            valid_reg;
    logic [tpe_pkg::STATUS_BITS-1:0] word_reg;
    logic [tpe_pkg::STATUS_BITS-1:0] acc_reg;
    logic [tpe_pkg::STATUS_BITS-1:0] acc_next;
    logic                            active;
    logic                            hit;

    always_comb
    begin
        active   = int'(count) > CELL_IDX;
        hit      = active && ((~tok_in.word & mask_reg) == '0);
        acc_next = hit ? (tok_in.acc | result_reg) : tok_in.acc;
    end

    always_ff @(posedge clk)
    begin
        if (load.we && (int'(load.index) == CELL_IDX))
        begin
            mask_reg   <= load.mask;
            result_reg <= load.result;
        end
        word_reg <= tok_in.word;
        acc_reg  <= acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= tok_in.valid;
        end
    end

    assign tok_out.valid = valid_reg;
    assign tok_out.word  = word_reg;
    assign tok_out.acc   = acc_reg;

endmodule

// ===== rtl/core/tpe_chain.sv =====
// row of term cells; a token walks one cell per cycle
module tpe_chain #(
    parameter int NUM_CELLS = tpe_pkg::PREP_TERMS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tpe_pkg::load_t              load,
    input  logic [tpe_pkg::COUNT_W-1:0] count,
    input  tpe_pkg::token_t             tok_in,
    output tpe_pkg::token_t             tok_out
);

    tpe_pkg::token_t tok [NUM_CELLS+1];

    assign tok[0]  = tok_in;
    assign tok_out = tok[NUM_CELLS];

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        tpe_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .load    (load),
            .count   (count),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
    end

endmodule

// ===== rtl/core/two_level_product_term_evaluator_top.sv =====
// top level: status word, command decode, prepare and main term chains, result queue
// set, clear, apply and load commands push their result beat into the registered queue
// evaluate walks the prepare chain, then the main chain (main only with no prepare terms)
// throughput 1 per cycle unless the queue is full; an evaluate stalls input for its whole walk,
// one term cell per cycle; a two-beat output queue lets a new command in while a result waits
// reset clears status, counts, pending flag and queue; term tables hold garbage until loaded
module two_level_product_term_evaluator_top #(
    parameter int PREP_TERMS_MAX = tpe_pkg::PREP_TERMS_DEF,
    parameter int MAIN_TERMS_MAX = tpe_pkg::MAIN_TERMS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  tpe_pkg::in_beat_t             in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output tpe_pkg::out_beat_t            out_data,
    input  logic                          cfg_we,
    input  logic [tpe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tpe_pkg::COUNT_W-1:0]   cfg_data
);

    tpe_pkg::state_t                 state_reg;
    tpe_pkg::state_t                 state_next;
    logic [tpe_pkg::STATUS_BITS-1:0] status_reg;
    logic [tpe_pkg::STATUS_BITS-1:0] status_next;
    logic                            pending_reg;
    logic                            pending_next;
    logic [tpe_pkg::COUNT_W-1:0]     prep_used_reg;
    logic [tpe_pkg::COUNT_W-1:0]     main_count_reg;
    tpe_pkg::out_beat_t              q0_reg;
    tpe_pkg::out_beat_t              q0_next;
    tpe_pkg::out_beat_t              q1_reg;
    tpe_pkg::out_beat_t              q1_next;
    logic [1:0]                      cnt_reg;
    logic [1:0]                      cnt_next;

    logic                            accept;
    logic                            push;
    logic                            pop;
    tpe_pkg::out_beat_t              push_beat;
    logic [tpe_pkg::STATUS_BITS-1:0] one_hot;
    logic [tpe_pkg::STATUS_BITS-1:0] word_a;
    logic [tpe_pkg::STATUS_BITS-1:0] word_b;
    tpe_pkg::load_t                  prep_load;
    tpe_pkg::load_t                  main_load;
    tpe_pkg::token_t                 prep_in;
    tpe_pkg::token_t                 prep_out;
    tpe_pkg::token_t                 main_in;
    tpe_pkg::token_t                 main_out;

    assign in_stall  = (state_reg != tpe_pkg::ST_IDLE) || (cnt_reg == 2'd2);
    assign accept    = in_valid && !in_stall;
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = q0_reg;
    assign pop       = out_valid && !out_stall;

    assign word_a  = {in_data.word_a_hi, in_data.word_a_lo};
    assign word_b  = {in_data.word_b_hi, in_data.word_b_lo};
    assign one_hot = {{(tpe_pkg::STATUS_BITS-1){1'b0}}, 1'b1} << in_data.bit_index;

    // term loads
    always_comb
    begin
        prep_load.we     = accept && (in_data.command == tpe_pkg::CMD_LOAD_PREP);
        prep_load.index  = in_data.entry_index;
        prep_load.mask   = word_a;
        prep_load.result = word_b;
        main_load.we     = accept && (in_data.command == tpe_pkg::CMD_LOAD_MAIN);
        main_load.index  = in_data.entry_index;
        main_load.mask   = word_a;
        main_load.result = word_b;
    end

    // command decode, token injection and sequencing
    always_comb
    begin
        state_next    = state_reg;
        status_next   = status_reg;
        pending_next  = pending_reg;
        push          = 1'b0;
        push_beat     = '0;
        prep_in.valid = 1'b0;
        prep_in.word  = status_reg;
        prep_in.acc   = '0;
        main_in.valid = 1'b0;
        main_in.word  = status_reg;
        main_in.acc   = '0;
        case (state_reg)
            tpe_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_data.command)
                        tpe_pkg::CMD_SET_BIT:   status_next = status_reg | one_hot;
                        tpe_pkg::CMD_CLEAR_BIT: status_next = status_reg & ~one_hot;
                        tpe_pkg::CMD_APPLY:     status_next = (status_reg & word_b) | word_a;
                        default:                status_next = status_reg;
                    endcase
                    if (status_next != status_reg)
                    begin
                        pending_next = 1'b1;
                    end
                    if (in_data.command == tpe_pkg::CMD_EVALUATE)
                    begin
                        pending_next = 1'b0;
                        if (prep_used_reg != '0)
                        begin
                            prep_in.valid = 1'b1;
                            state_next    = tpe_pkg::ST_PREP;
                        end
                        else
                        begin
                            main_in.valid = 1'b1;
                            state_next    = tpe_pkg::ST_MAIN;
                        end
                    end
                    else
                    begin
                        push                     = 1'b1;
                        push_beat.recalc_pending = pending_next;
                    end
                end
            end
            tpe_pkg::ST_PREP:
            begin
                if (prep_out.valid)
                begin
                    main_in.valid = 1'b1;
                    main_in.word  = prep_out.word | prep_out.acc;
                    state_next    = tpe_pkg::ST_MAIN;
                end
            end
            tpe_pkg::ST_MAIN:
            begin
                if (main_out.valid)
                begin
                    push              = 1'b1;
                    push_beat.eval_lo = main_out.acc[tpe_pkg::HALF_BITS-1:0];
                    push_beat.eval_hi = main_out.acc[tpe_pkg::STATUS_BITS-1:tpe_pkg::HALF_BITS];
                    push_beat.recalc_pending = pending_reg;
                    state_next        = tpe_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tpe_pkg::ST_IDLE;
            end
        endcase
    end

    // two-beat output queue
    always_comb
    begin
        q0_next  = q0_reg;
        q1_next  = q1_reg;
        cnt_next = cnt_reg;
        if (pop)
        begin
            q0_next = q1_reg;
        end
        if (push)
        begin
            if ((cnt_reg == 2'd0) || (pop && (cnt_reg == 2'd1)))
            begin
                q0_next = push_beat;
            end
            else
            begin
                q1_next = push_beat;
            end
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tpe_pkg::ST_IDLE;
            status_reg     <= '0;
            pending_reg    <= 1'b0;
            prep_used_reg  <= '0;
            main_count_reg <= '0;
            cnt_reg        <= 2'd0;
        end
        else
        begin
            state_reg   <= state_next;
            status_reg  <= status_next;
            pending_reg <= pending_next;
            cnt_reg     <= cnt_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    tpe_pkg::CFG_PREP_COUNT: prep_used_reg  <= cfg_data;
                    tpe_pkg::CFG_MAIN_COUNT: main_count_reg <= cfg_data;
                    default:                 prep_used_reg  <= prep_used_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    tpe_chain #(
        .NUM_CELLS (PREP_TERMS_MAX)
    ) u_prep_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (prep_load),
        .count   (prep_used_reg),
        .tok_in  (prep_in),
        .tok_out (prep_out)
    );

    tpe_chain #(
        .NUM_CELLS (MAIN_TERMS_MAX)
    ) u_main_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (main_load),
        .count   (main_count_reg),
        .tok_in  (main_in),
        .tok_out (main_out)
    );

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("output queue count out of range");

    a_prep_exit: assert property (@(posedge clk) disable iff (!rst_n)
        prep_out.valid |-> (state_reg == tpe_pkg::ST_PREP))
        else $error("prepare token left chain outside prepare pass");

    a_main_exit: assert property (@(posedge clk) disable iff (!rst_n)
        main_out.valid |-> (state_reg == tpe_pkg::ST_MAIN))
        else $error("main token left chain outside main pass");

    a_eval_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_data.command == tpe_pkg::CMD_EVALUATE)) |=> !pending_reg)
        else $error("evaluate did not clear pending flag");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ((cnt_reg != 2'd2) || pop))
        else $error("result pushed into full queue");

endmodule
